// ----- rtl/lndc_pkg.sv -----
// Shared types, constants and mask weights for the 3x3 line-detection convolution.
package lndc_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int PIX_W      = 8;
  localparam int POS_W      = 11;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int MODE_W     = 2;
  localparam int SUM_W      = 12;
  localparam int MIN_DIM    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MASK_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [MODE_W-1:0] MODE_HORIZONTAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_VERTICAL   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_LEFT_DIAG  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT_DIAG = 2'd3;

  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = 12'd2048;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = 12'd2048;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [2:0] weight_t;

  typedef struct packed {
    logic load;
    logic retire;
  } lb_ctrl_t;

  // weights indexed [mode][column offset][row offset]
  localparam weight_t LINE_MASKS [4][3][3] = '{
    '{'{-3'sd1, 3'sd2, -3'sd1}, '{-3'sd1, 3'sd2, -3'sd1}, '{-3'sd1, 3'sd2, -3'sd1}},
    '{'{-3'sd1, -3'sd1, -3'sd1}, '{3'sd2, 3'sd2, 3'sd2}, '{-3'sd1, -3'sd1, -3'sd1}},
    '{'{3'sd2, -3'sd1, -3'sd1}, '{-3'sd1, 3'sd2, -3'sd1}, '{-3'sd1, -3'sd1, 3'sd2}},
    '{'{-3'sd1, -3'sd1, 3'sd2}, '{-3'sd1, 3'sd2, -3'sd1}, '{3'sd2, -3'sd1, -3'sd1}}
  };

  function automatic sum_t mask_term(logic [MODE_W-1:0] mode, logic [1:0] dx,
                                     logic [1:0] dy, pixel_t p);
    sum_t pv;
    sum_t wv;
    pv = sum_t'($signed({1'b0, p}));
    wv = sum_t'(LINE_MASKS[mode][dx][dy]);
    return pv * wv;
  endfunction

endpackage

// ----- rtl/lndc_line_buffer.sv -----
// Two line stores holding the previous two image rows, with write forwarding.
module lndc_line_buffer #(
  parameter int MAX_WIDTH = lndc_pkg::MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  lndc_pkg::lb_ctrl_t           ctrl,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  lndc_pkg::pixel_t             pix,
  output lndc_pkg::pixel_t             top,
  output lndc_pkg::pixel_t             mid
);
  import lndc_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  pixel_t         store_a [MAX_WIDTH];
  pixel_t         store_b [MAX_WIDTH];
  pixel_t         a_rd;
  pixel_t         b_rd;
  pixel_t         fwd_data;
  logic           fwd_hit;
  logic [AW-1:0]  addr_held;

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      a_rd <= store_a[addr];
      store_a[addr] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      b_rd <= store_b[addr];
    end
    if (ctrl.retire) begin
      store_b[addr_held] <= a_rd;
    end
  end

  // catch a read of the entry that the retiring word writes in the same cycle
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      fwd_hit   <= ctrl.retire && (addr == addr_held);
      fwd_data  <= a_rd;
      addr_held <= addr;
    end
  end

  assign mid = a_rd;
  assign top = fwd_hit ? fwd_data : b_rd;

endmodule

// ----- rtl/lndc_window_mac.sv -----
// 3x3 window registers, mask weighted sum and clamp to the pixel range.
module lndc_window_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                advance,
  input  lndc_pkg::pixel_t                    top,
  input  lndc_pkg::pixel_t                    mid,
  input  lndc_pkg::pixel_t                    pix,
  input  logic [lndc_pkg::MODE_W-1:0]         mode,
  output lndc_pkg::pixel_t                    result
);
  import lndc_pkg::*;

  pixel_t [2:0][2:0] win;
  pixel_t [2:0][2:0] win_next;
  sum_t              sum;

  always_comb begin
    for (int dy = 0; dy < 3; dy++) begin
      win_next[dy][0] = win[dy][1];
      win_next[dy][1] = win[dy][2];
    end
    win_next[0][2] = top;
    win_next[1][2] = mid;
    win_next[2][2] = pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (advance) begin
      win <= win_next;
    end
  end

  always_comb begin
    sum = '0;
    for (int dx = 0; dx < 3; dx++) begin
      for (int dy = 0; dy < 3; dy++) begin
        sum = sum + mask_term(mode, 2'(dx), 2'(dy), win_next[dy][dx]);
      end
    end
  end

  always_comb begin
    if (sum < 0) begin
      result = '0;
    end else if (sum > sum_t'(255)) begin
      result = '1;
    end else begin
      result = sum[PIX_W-1:0];
    end
  end

endmodule

// ----- rtl/line_detect_3x3_conv_core.sv -----
// Top level of the 3x3 line-detection convolution: position, handshake and result register.
//
// Takes one 8-bit pixel per clock in raster order, unless in_stall holds it, and gives one
// filtered word for every interior pixel through the input stage and the result register
// after the pixel that completes its neighbourhood is accepted; border pixels give no word.
// The rate is set by the single read and write port of each line store (MAX_WIDTH entries
// of 8 bits, two stores). The result register lets a new pixel in while a word waits to be
// taken. Configuration must be written only while the block is idle; it is not enforced.
module line_detect_3x3_conv_core #(
  parameter int MAX_WIDTH  = lndc_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = lndc_pkg::MAX_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_en,
  input  logic [lndc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lndc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  lndc_pkg::pixel_t                    pixel_in,
  input  logic                                frame_start,
  output logic                                out_valid,
  input  logic                                out_stall,
  output lndc_pkg::pixel_t                    pixel_out,
  output logic [lndc_pkg::POS_W-1:0]          out_col,
  output logic [lndc_pkg::POS_W-1:0]          out_row,
  output logic                                frame_last
);
  import lndc_pkg::*;

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int MW   = (CW > RW) ? CW : RW;
  localparam int CMPW = ((MW > CFG_DATA_W) ? MW : CFG_DATA_W) + 1;

  logic [MODE_W-1:0]     mask_mode;
  logic [CFG_DATA_W-1:0] image_width;
  logic [CFG_DATA_W-1:0] image_height;

  logic [CW-1:0]   col_count;
  logic [RW-1:0]   row_count;
  logic [CW-1:0]   col_count_next;
  logic [RW-1:0]   row_count_next;

  logic [CW-1:0]   c0;
  logic [RW-1:0]   r0;
  logic [CMPW-1:0] c_ext;
  logic [CMPW-1:0] r_ext;
  logic [CMPW-1:0] c_inc;
  logic [CMPW-1:0] r_inc;
  logic [CMPW-1:0] w_raw;
  logic [CMPW-1:0] h_raw;
  logic [CMPW-1:0] w_eff;
  logic [CMPW-1:0] h_eff;
  logic            interior;
  logic            last;

  logic            accept;
  logic            out_free;
  logic            adv1;

  logic            s1_valid;
  pixel_t          s1_pix;
  logic            s1_interior;
  logic            s1_last;
  logic [CW-1:0]   s1_col;
  logic [RW-1:0]   s1_row;
  logic [CMPW-1:0] col_m1;
  logic [CMPW-1:0] row_m1;

  lb_ctrl_t        lb_ctrl;
  pixel_t          top;
  pixel_t          mid;
  pixel_t          result;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask_mode    <= MODE_HORIZONTAL;
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_MASK_MODE:    mask_mode    <= cfg_data[MODE_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_raw = CMPW'(image_width);
    h_raw = CMPW'(image_height);
    if (w_raw < CMPW'(MIN_DIM)) begin
      w_eff = CMPW'(MIN_DIM);
    end else if (w_raw > CMPW'(MAX_WIDTH)) begin
      w_eff = CMPW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (h_raw < CMPW'(MIN_DIM)) begin
      h_eff = CMPW'(MIN_DIM);
    end else if (h_raw > CMPW'(MAX_HEIGHT)) begin
      h_eff = CMPW'(MAX_HEIGHT);
    end else begin
      h_eff = h_raw;
    end
  end

  always_comb begin
    c0       = frame_start ? '0 : col_count;
    r0       = frame_start ? '0 : row_count;
    c_ext    = CMPW'(c0);
    r_ext    = CMPW'(r0);
    c_inc    = c_ext + CMPW'(1);
    r_inc    = r_ext + CMPW'(1);
    interior = (c_ext >= CMPW'(2)) && (r_ext >= CMPW'(2));
    last     = (c_ext == w_eff - CMPW'(1)) && (r_ext == h_eff - CMPW'(1));
    if (c_inc >= w_eff) begin
      col_count_next = '0;
      row_count_next = (r_inc >= h_eff) ? '0 : r_inc[RW-1:0];
    end else begin
      col_count_next = c_inc[CW-1:0];
      row_count_next = r0;
    end
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign accept   = in_valid && !in_stall;
  assign adv1     = s1_valid && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv1) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pixel_in;
      s1_interior <= interior;
      s1_last     <= last;
      s1_col      <= c0;
      s1_row      <= r0;
    end
  end

  assign lb_ctrl.load   = accept;
  assign lb_ctrl.retire = adv1;

  lndc_line_buffer #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_buffer (
    .clk  (clk),
    .ctrl (lb_ctrl),
    .addr (c0),
    .pix  (pixel_in),
    .top  (top),
    .mid  (mid)
  );

  lndc_window_mac u_window_mac (
    .clk     (clk),
    .rst     (rst),
    .advance (adv1),
    .top     (top),
    .mid     (mid),
    .pix     (s1_pix),
    .mode    (mask_mode),
    .result  (result)
  );

  assign col_m1 = CMPW'(s1_col) - CMPW'(1);
  assign row_m1 = CMPW'(s1_row) - CMPW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= adv1 && s1_interior;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && adv1 && s1_interior) begin
      pixel_out  <= result;
      out_col    <= col_m1[POS_W-1:0];
      out_row    <= row_m1[POS_W-1:0];
      frame_last <= s1_last;
    end
  end

`ifndef SYNTHESIS
  a_frame_start_pos: assert property (@(posedge clk) disable iff (rst)
    accept && frame_start |=> (col_count == CW'(1)) && (row_count == '0))
    else $error("position not restarted by frame start");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid && s1_interior))
    else $error("result word without an interior pixel behind it");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && in_stall |=> s1_valid && $stable(s1_col) && $stable(s1_pix))
    else $error("held pixel lost while output stalled");
`endif

endmodule

// ----- tb/line_detect_3x3_conv_core_test.sv -----
// Self-checking testbench for the 3x3 line-detection convolution core.
module line_detect_3x3_conv_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lndc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned HOLD_CYCLES   = 150;

  typedef struct {
    pixel_t           value;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } filtered_t;

  class conv_scoreboard;
    pixel_t                prev_row  [MAX_WIDTH_DEF];
    pixel_t                older_row [MAX_WIDTH_DEF];
    pixel_t                win [3][3];
    int unsigned           col_pos;
    int unsigned           row_pos;
    logic [MODE_W-1:0]     mode;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    filtered_t             due_words [$];
    int unsigned           errors;
    int unsigned           words_checked;

    function new();
      foreach (prev_row[i]) begin
        prev_row[i]  = '0;
        older_row[i] = '0;
      end
      foreach (win[i, j]) win[i][j] = '0;
      col_pos       = 0;
      row_pos       = 0;
      mode          = MODE_HORIZONTAL;
      width_reg     = WIDTH_RST;
      height_reg    = HEIGHT_RST;
      errors        = 0;
      words_checked = 0;
    endfunction

    static function int unsigned span(logic [CFG_DATA_W-1:0] v, int unsigned hi);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > hi) return hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MASK_MODE:    mode = data[MODE_W-1:0];
        REG_IMAGE_WIDTH:  width_reg = data;
        REG_IMAGE_HEIGHT: height_reg = data;
        default: ;
      endcase
    endfunction

    function int weight(int dx, int dy);
      case (mode)
        MODE_HORIZONTAL: return (dy == 1) ? 2 : -1;
        MODE_VERTICAL:   return (dx == 1) ? 2 : -1;
        MODE_LEFT_DIAG:  return (dx == dy) ? 2 : -1;
        default:         return (dx + dy == 2) ? 2 : -1;
      endcase
    endfunction

    function void note_pixel(pixel_t pix, logic fs);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      int unsigned idx;
      pixel_t      top;
      pixel_t      mid;
      int          acc;
      filtered_t   word;
      w = span(width_reg, MAX_WIDTH_DEF);
      h = span(height_reg, MAX_HEIGHT_DEF);
      if (fs) begin
        col_pos = 0;
        row_pos = 0;
      end
      c = col_pos;
      r = row_pos;
      idx = c % MAX_WIDTH_DEF;
      top = older_row[idx];
      mid = prev_row[idx];
      older_row[idx] = mid;
      prev_row[idx]  = pix;
      for (int dy = 0; dy < 3; dy++) begin
        win[dy][0] = win[dy][1];
        win[dy][1] = win[dy][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = pix;
      if (c >= 2 && r >= 2) begin
        acc = 0;
        for (int dx = 0; dx < 3; dx++)
          for (int dy = 0; dy < 3; dy++)
            acc += int'(win[dy][dx]) * weight(dx, dy);
        if (acc > 255) acc = 255;
        if (acc < 0) acc = 0;
        word.value = pixel_t'(acc);
        word.col   = POS_W'(c - 1);
        word.row   = POS_W'(r - 1);
        word.last  = (c == w - 1) && (r == h - 1);
        due_words.push_back(word);
      end
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
    endfunction

    function void check_word(pixel_t value, logic [POS_W-1:0] col, logic [POS_W-1:0] row,
                             logic last);
      filtered_t want;
      if (due_words.size() == 0) begin
        $error("unexpected word: pixel_out %0d out_col %0d out_row %0d frame_last %0d",
               value, col, row, last);
        errors++;
        return;
      end
      want = due_words.pop_front();
      words_checked++;
      if (value !== want.value) begin
        $error("pixel_out expected %0d got %0d", want.value, value);
        errors++;
      end
      if (col !== want.col) begin
        $error("out_col expected %0d got %0d", want.col, col);
        errors++;
      end
      if (row !== want.row) begin
        $error("out_row expected %0d got %0d", want.row, row);
        errors++;
      end
      if (last !== want.last) begin
        $error("frame_last expected %0d got %0d", want.last, last);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst          = 1'b1;
  logic                  cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = REG_MASK_MODE;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  in_valid     = 1'b0;
  logic                  in_stall;
  pixel_t                pixel_in     = '0;
  logic                  frame_start  = 1'b0;
  logic                  out_valid;
  logic                  out_stall    = 1'b0;
  pixel_t                pixel_out;
  logic [POS_W-1:0]      out_col;
  logic [POS_W-1:0]      out_row;
  logic                  frame_last;

  conv_scoreboard sb;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_stall_pct = 0;
  int unsigned    hold_budget = 0;
  int unsigned    pixels_sent = 0;

  line_detect_3x3_conv_core u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_in     (pixel_in),
    .frame_start  (frame_start),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_out    (pixel_out),
    .out_col      (out_col),
    .out_row      (out_row),
    .frame_last   (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic pixel_t rand_pixel();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pixel_t'($urandom_range(255));
    endcase
  endfunction

  task automatic send_pixel(input pixel_t p, input logic fs);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    pixel_in    <= p;
    frame_start <= fs;
    do @(posedge clk); while (in_stall);
    sb.note_pixel(p, fs);
    pixels_sent++;
  endtask

  // drop valid and hold until every expected word is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [MODE_W-1:0] mode, input logic [CFG_DATA_W-1:0] w,
                           input logic [CFG_DATA_W-1:0] h);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_MASK_MODE;
    cfg_data     <= CFG_DATA_W'(mode);
    @(posedge clk);
    sb.write_reg(REG_MASK_MODE, CFG_DATA_W'(mode));
    cfg_index <= REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    sb.write_reg(REG_IMAGE_WIDTH, w);
    cfg_index <= REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    sb.write_reg(REG_IMAGE_HEIGHT, h);
    cfg_write_en <= 1'b0;
  endtask

  task automatic send_frame(input int unsigned w, input int unsigned h, input bit lead,
                            input bit clean, output int unsigned count);
    int unsigned n;
    n = w * h;
    if (!clean && $urandom_range(9) == 0) n = $urandom_range(n, 1);
    for (int unsigned i = 0; i < n; i++)
      send_pixel(rand_pixel(), (i == 0 && lead) || (!clean && i != 0 && $urandom_range(99) == 0));
    count = n;
  endtask

  task automatic run_phase(input logic [MODE_W-1:0] mode, input logic [CFG_DATA_W-1:0] w_data,
                           input logic [CFG_DATA_W-1:0] h_data, input int unsigned quota,
                           input bit clean);
    int unsigned w;
    int unsigned h;
    int unsigned sent;
    int unsigned n;
    bit          first;
    configure(mode, w_data, h_data);
    w = conv_scoreboard::span(w_data, MAX_WIDTH_DEF);
    h = conv_scoreboard::span(h_data, MAX_HEIGHT_DEF);
    sent = 0;
    first = 1'b1;
    while (sent < quota) begin
      send_frame(w, h, first || $urandom_range(99) < 80, clean, n);
      sent += n;
      first = 1'b0;
    end
    wait_drained();
  endtask

  initial begin : receiver
    int unsigned held;
    held = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall)
        sb.check_word(pixel_out, out_col, out_row, frame_last);
      if (hold_budget != 0 && held < hold_budget) begin
        out_stall <= 1'b1;
        held++;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    logic [MODE_W-1:0]     mode;
    logic [CFG_DATA_W-1:0] wd;
    logic [CFG_DATA_W-1:0] hd;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset sizes: a short run along row 0 gives no words
    for (int i = 0; i < 10; i++) send_pixel(rand_pixel(), i == 0);
    wait_drained();

    // width and height below range saturate to 3
    configure(MODE_HORIZONTAL, 12'd1, 12'd0);
    for (int i = 0; i < 9; i++) send_pixel((i / 3 == 1) ? 8'hFF : 8'h00, i == 0);
    wait_drained();
    // next frame starts by wrapping, no frame_start
    configure(MODE_VERTICAL, 12'd2, 12'd2);
    for (int i = 0; i < 9; i++) send_pixel((i % 3 == 1) ? 8'h00 : 8'hFF, 1'b0);
    wait_drained();
    configure(MODE_RIGHT_DIAG, 12'd3, 12'd3);
    for (int i = 0; i < 9; i++) send_pixel(((i / 3 + i % 3) % 2 != 0) ? 8'hFF : 8'h00, i == 0);
    wait_drained();

    for (int unsigned ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      if (ph == 0) hold_budget = HOLD_CYCLES;
      mode = MODE_W'((ph + ph / 4) % 4);
      wd = CFG_DATA_W'($urandom_range(12, 3));
      hd = CFG_DATA_W'($urandom_range(8, 3));
      if (ph == 2) wd = CFG_DATA_W'($urandom_range(2, 0));
      if (ph == 5) hd = CFG_DATA_W'($urandom_range(2, 0));
      run_phase(mode, wd, hd, 30, 1'b0);
    end

    // shrink both sizes part way through a frame so the position wraps
    send_idle_pct = 16;
    recv_stall_pct = 16;
    configure(MODE_LEFT_DIAG, 12'd10, 12'd8);
    for (int i = 0; i < 48; i++) send_pixel(rand_pixel(), i == 0);
    wait_drained();
    configure(MODE_LEFT_DIAG, 12'd5, 12'd4);
    for (int i = 0; i < 30; i++) send_pixel(rand_pixel(), 1'b0);
    wait_drained();

    // sizes above range saturate to the maximum: part of a wide row, part of a tall column
    configure(MODE_VERTICAL, 12'd4095, 12'd3);
    for (int i = 0; i < 40; i++) send_pixel(rand_pixel(), i == 0);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure(MODE_HORIZONTAL, 12'd3, 12'd4095);
    for (int i = 0; i < 60; i++) send_pixel(rand_pixel(), i == 0);
    wait_drained();

    $display("Checked %0d filtered words from %0d pixels over all four masks,",
             sb.words_checked, pixels_sent);
    $display("small and saturated frame sizes, clamping both ends, mid-frame wraps, stalls.");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
